// File: sv/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg - shared types and constants for the piecewise linear interpolator
// Field layout of the streams, table geometry, FSM state types and the
// request/response structs of the serial multiply/divide unit.
// ----------------------------------------------------------------------------
package pli_pkg;

	localparam int DATA_W     = 16;
	localparam int MAX_POINTS = 8;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = 4;
	localparam int CNT_RESET  = 8;

	// accumulator for y0*den + dy*dx, with headroom for partial sums
	localparam int ACC_W  = 2 * DATA_W + 3;
	localparam int SER_W  = $clog2(DATA_W);

	// s_tdata layout: entry_index, x_value, y_value from bit 0 up
	localparam int IDX_LSB  = 0;
	localparam int X_LSB    = IDX_LSB + IDX_W;
	localparam int Y_LSB    = X_LSB + DATA_W;
	localparam int S_FLD_W  = Y_LSB + DATA_W;
	localparam int S_DATA_W = ((S_FLD_W + 7) / 8) * 8;
	localparam int M_DATA_W = DATA_W;

	// APB
	localparam int ADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [ADDR_W-3:0] REG_POINT_COUNT = '0;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK0,
		ST_CHKN,
		ST_SCAN,
		ST_CALC,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		MD_IDLE,
		MD_MUL,
		MD_NORM,
		MD_DIV,
		MD_DONE
	} md_state_t;

	typedef struct packed {
		logic [DATA_W-1:0] y;
		logic [DATA_W-1:0] x;
	} entry_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] y0;
		logic [DATA_W:0]   dy;
		logic [DATA_W-1:0] dx;
		logic [DATA_W-1:0] den;
	} md_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quo;
	} md_rsp_t;

endpackage

// File: sv/pli_muldiv.sv
// ----------------------------------------------------------------------------
// pli_muldiv - bit-serial y0*den + dy*dx followed by a serial divide by den
// Multiply: one bit of den and dx per cycle. Divide: one quotient bit per
// cycle, restoring, on the magnitude; sign applied at the end (trunc to zero).
// ----------------------------------------------------------------------------
module pli_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  pli_pkg::md_req_t  req,
	output pli_pkg::md_rsp_t  rsp
);

	localparam int DW = pli_pkg::DATA_W;
	localparam int AW = pli_pkg::ACC_W;
	localparam logic [pli_pkg::SER_W-1:0] CNT_LAST = pli_pkg::SER_W'(DW - 1);

	pli_pkg::md_state_t state_q, state_next;

	logic [pli_pkg::SER_W-1:0] cnt_q;
	logic [AW-1:0]             acc_q, m0_q, m1_q;
	logic [DW-1:0]             b0_q, b1_q, den_q;
	logic [DW-1:0]             rem_q, quo_q;
	logic                      neg_q;

	logic [AW-1:0] mag;
	logic [DW:0]   trial;
	logic          ge;

	assign mag   = acc_q[AW-1] ? (~acc_q + 1'b1) : acc_q;
	assign trial = {rem_q, quo_q[DW-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_comb begin
		state_next = state_q;
		case (state_q)
			pli_pkg::MD_IDLE: if (req.start) state_next = pli_pkg::MD_MUL;
			pli_pkg::MD_MUL:  if (cnt_q == CNT_LAST) state_next = pli_pkg::MD_NORM;
			pli_pkg::MD_NORM: state_next = pli_pkg::MD_DIV;
			pli_pkg::MD_DIV:  if (cnt_q == CNT_LAST) state_next = pli_pkg::MD_DONE;
			pli_pkg::MD_DONE: state_next = pli_pkg::MD_IDLE;
			default:          state_next = pli_pkg::MD_IDLE;
		endcase
	end

	always_comb begin
		rsp.done = (state_q == pli_pkg::MD_DONE);
		rsp.quo  = neg_q ? (~quo_q + 1'b1) : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pli_pkg::MD_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == pli_pkg::MD_MUL || state_q == pli_pkg::MD_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pli_pkg::MD_IDLE: begin
				if (req.start) begin
					acc_q <= '0;
					m0_q  <= {{(AW-DW){req.y0[DW-1]}}, req.y0};
					m1_q  <= {{(AW-DW-1){req.dy[DW]}}, req.dy};
					b0_q  <= req.den;
					b1_q  <= req.dx;
					den_q <= req.den;
				end
			end
			pli_pkg::MD_MUL: begin
				acc_q <= acc_q + (b0_q[0] ? m0_q : '0) + (b1_q[0] ? m1_q : '0);
				m0_q  <= {m0_q[AW-2:0], 1'b0};
				m1_q  <= {m1_q[AW-2:0], 1'b0};
				b0_q  <= {1'b0, b0_q[DW-1:1]};
				b1_q  <= {1'b0, b1_q[DW-1:1]};
			end
			pli_pkg::MD_NORM: begin
				// |num| < 2^31 and its upper half is below den
				neg_q <= acc_q[AW-1];
				rem_q <= mag[2*DW-1:DW];
				quo_q <= mag[DW-1:0];
			end
			pli_pkg::MD_DIV: begin
				rem_q <= ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
				quo_q <= {quo_q[DW-2:0], ge};
			end
			default: begin
			end
		endcase
	end

endmodule

// File: sv/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator - breakpoint table with linear interpolation
// Eight-entry (x, y) table loaded by write items; query items return the
// interpolated y, truncated toward zero, or the end y when clamped.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: s_tuser is the command (0 write, 1 query). s_tdata
//   carries entry_index, x_value and y_value. A write loads the slot in the
//   cycle it is taken and gives no result item. A query gives exactly one
//   result item on m_*: m_tdata is y_out, m_tuser is the clamped flag.
//   APB port: register 0 (byte address 0) is point_count, 4 bits, reset 8;
//   values below 2 act as 2, above 8 act as 8. Write only while idle.
// Sequence:
//   One item at a time. A clamped query at the low end goes through ST_CHK0
//   and ST_DONE, at the high end through ST_CHK0, ST_CHKN and ST_DONE.
//   An interpolated query (n active points) runs through
//   two end checks, a scan of up to n-1 table reads, then
//   pli_muldiv (bit-serial multiply, one normalize, divide, one done)
//   and ST_DONE, which loads the output register once it is free.
// Reset and stall:
//   Reset clears the FSM, the output valid and point_count (to 8); table
//   contents are undefined until written. Results sit in an output register;
//   s_tready is back high once the result is loaded there, so the next item
//   is taken while m_tready is low. A second result waits inside the block.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator (
	input  logic                          clk,
	input  logic                          arst_n,
	// slave stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pli_pkg::S_DATA_W-1:0]  s_tdata,   // entry_index, x_value, y_value, pad
	input  logic [0:0]                    s_tuser,   // cmd
	// master stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pli_pkg::M_DATA_W-1:0]  m_tdata,   // y_out
	output logic [0:0]                    m_tuser,   // clamped
	// APB config
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pli_pkg::ADDR_W-1:0]    paddr,
	input  logic [pli_pkg::PDATA_W-1:0]   pwdata,
	output logic [pli_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int DW = pli_pkg::DATA_W;
	localparam int IW = pli_pkg::IDX_W;
	localparam int CW = pli_pkg::CNT_W;

	pli_pkg::state_t state_q, state_next;

	// config
	logic [CW-1:0] count_q;
	logic [CW-1:0] n_eff;
	logic [IW-1:0] last_idx;
	logic          cfg_wr;

	// table memory, one registered read port
	pli_pkg::entry_t mem_q [pli_pkg::MAX_POINTS];
	pli_pkg::entry_t rd_q;
	logic [IW-1:0]   rd_addr;

	// query context
	logic [DW-1:0]   x_q;
	pli_pkg::entry_t prev_q;
	logic [IW-1:0]   idx_q;
	logic [DW-1:0]   res_y_q;
	logic            res_clamp_q;

	// output register
	logic          m_tvalid_q;
	logic [DW-1:0] m_y_q;
	logic          m_clamp_q;
	logic          out_free;

	logic          s_acc;
	logic [IW-1:0] s_idx;
	logic [DW-1:0] s_x, s_y;
	logic          le_first, ge_last, scan_more;
	logic [DW:0]   dx_w, den_w, dy_w;

	pli_pkg::md_req_t md_req;
	pli_pkg::md_rsp_t md_rsp;

	assign s_idx = s_tdata[pli_pkg::IDX_LSB +: IW];
	assign s_x   = s_tdata[pli_pkg::X_LSB +: DW];
	assign s_y   = s_tdata[pli_pkg::Y_LSB +: DW];
	assign s_acc = s_tvalid && s_tready;

	// ---- configuration ----
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[pli_pkg::ADDR_W-1:2] == pli_pkg::REG_POINT_COUNT);
	assign prdata = (paddr[pli_pkg::ADDR_W-1:2] == pli_pkg::REG_POINT_COUNT)
		? pli_pkg::PDATA_W'(count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(pli_pkg::CNT_RESET);
		end else if (cfg_wr) begin
			count_q <= pwdata[CW-1:0];
		end
	end

	always_comb begin
		if (count_q < CW'(2)) begin
			n_eff = CW'(2);
		end else if (count_q > CW'(pli_pkg::MAX_POINTS)) begin
			n_eff = CW'(pli_pkg::MAX_POINTS);
		end else begin
			n_eff = count_q;
		end
	end
	assign last_idx = IW'(n_eff - 1'b1);

	// ---- table ----
	always_ff @(posedge clk) begin
		if (s_acc && s_tuser == pli_pkg::CMD_WRITE) begin
			mem_q[s_idx] <= '{y: s_y, x: s_x};
		end
		rd_q <= mem_q[rd_addr];
	end

	// ---- segment search compares ----
	assign le_first  = $signed(x_q) <= $signed(rd_q.x);
	assign ge_last   = $signed(x_q) >= $signed(rd_q.x);
	assign scan_more = (idx_q < last_idx) && ($signed(x_q) > $signed(rd_q.x));

	// x0 < x <= x1 holds on the interpolated path, so dx and den are positive
	assign dx_w  = {x_q[DW-1], x_q} - {prev_q.x[DW-1], prev_q.x};
	assign den_w = {rd_q.x[DW-1], rd_q.x} - {prev_q.x[DW-1], prev_q.x};
	assign dy_w  = {rd_q.y[DW-1], rd_q.y} - {prev_q.y[DW-1], prev_q.y};

	assign out_free = !m_tvalid_q || m_tready;

	// ---- FSM ----
	always_comb begin
		state_next = state_q;
		case (state_q)
			pli_pkg::ST_IDLE: if (s_tvalid && s_tuser == pli_pkg::CMD_QUERY)
				state_next = pli_pkg::ST_CHK0;
			pli_pkg::ST_CHK0: state_next = le_first ? pli_pkg::ST_DONE : pli_pkg::ST_CHKN;
			pli_pkg::ST_CHKN: state_next = ge_last ? pli_pkg::ST_DONE : pli_pkg::ST_SCAN;
			pli_pkg::ST_SCAN: if (!scan_more) state_next = pli_pkg::ST_CALC;
			pli_pkg::ST_CALC: if (md_rsp.done) state_next = pli_pkg::ST_DONE;
			pli_pkg::ST_DONE: if (out_free) state_next = pli_pkg::ST_IDLE;
			default:          state_next = pli_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = (state_q == pli_pkg::ST_IDLE);
		md_req.y0  = prev_q.y;
		md_req.dy  = dy_w;
		md_req.dx  = dx_w[DW-1:0];
		md_req.den = den_w[DW-1:0];
		md_req.start = 1'b0;
		case (state_q)
			pli_pkg::ST_IDLE: rd_addr = '0;
			pli_pkg::ST_CHK0: rd_addr = last_idx;
			pli_pkg::ST_CHKN: rd_addr = IW'(1);
			pli_pkg::ST_SCAN: begin
				rd_addr      = idx_q + 1'b1;
				md_req.start = !scan_more;
			end
			default:          rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pli_pkg::ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == pli_pkg::ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pli_pkg::ST_IDLE: if (s_acc) x_q <= s_x;
			pli_pkg::ST_CHK0: begin
				prev_q      <= rd_q;
				res_y_q     <= rd_q.y;
				res_clamp_q <= 1'b1;
			end
			pli_pkg::ST_CHKN: begin
				res_y_q     <= rd_q.y;
				res_clamp_q <= 1'b1;
				idx_q       <= IW'(1);
			end
			pli_pkg::ST_SCAN: begin
				if (scan_more) begin
					prev_q <= rd_q;
					idx_q  <= idx_q + 1'b1;
				end
			end
			pli_pkg::ST_CALC: begin
				if (md_rsp.done) begin
					res_y_q     <= md_rsp.quo;
					res_clamp_q <= 1'b0;
				end
			end
			pli_pkg::ST_DONE: begin
				if (out_free) begin
					m_y_q     <= res_y_q;
					m_clamp_q <= res_clamp_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_y_q;
	assign m_tuser  = m_clamp_q;

	pli_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

endmodule

// File: sv/pli_checker.sv
// ----------------------------------------------------------------------------
// pli_checker - port-level checks for the piecewise linear interpolator
// Sees only the top-level ports; attached by bind below.
// ----------------------------------------------------------------------------
module pli_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [0:0]                    s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [pli_pkg::M_DATA_W-1:0]  m_tdata,
	input logic [0:0]                    m_tuser,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [pli_pkg::ADDR_W-1:0]    paddr,
	input logic [pli_pkg::PDATA_W-1:0]   pwdata,
	input logic [pli_pkg::PDATA_W-1:0]   prdata,
	input logic                          pready
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a query keeps the block busy for at least the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == pli_pkg::CMD_QUERY |=> !s_tready)
		else $error("input taken right after a query");

	// a new result only comes out of a query in flight
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without a query in flight");

	// point_count reads back what was written
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready
		&& paddr[pli_pkg::ADDR_W-1:2] == pli_pkg::REG_POINT_COUNT
		|=> paddr[pli_pkg::ADDR_W-1:2] != pli_pkg::REG_POINT_COUNT
		|| prdata[pli_pkg::CNT_W-1:0] == $past(pwdata[pli_pkg::CNT_W-1:0]))
		else $error("point_count readback mismatch");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata),
	.pready   (pready)
);
